>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros, reset-qualified on clk/rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/qslerp_pkg.sv
// ----------------------------------------------------------------------------
// qslerp_pkg
// Types, constants and stage map of the quaternion slerp pipeline.
// ----------------------------------------------------------------------------
package qslerp_pkg;

  localparam int FRAC_BITS    = 14;
  localparam int ANG_BITS     = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = ANG_BITS + 1;
  localparam int QUO_BITS     = 45;
  localparam int SQ_W         = 2 * ANG_BITS + 2;
  localparam int REM_W        = 33;
  localparam int SPLIT        = 24;

  // stage map, stage 1 registers the input transfer
  localparam int ST_C2   = 4;
  localparam int ST_SQRT = ST_C2 + SQRT_STEPS;
  localparam int ST_ATAN = ST_SQRT + CORDIC_STEPS;
  localparam int ST_MUL  = ST_ATAN + 1;
  localparam int ST_SIN  = ST_MUL + CORDIC_STEPS;
  localparam int ST_DIV  = ST_SIN + 1 + QUO_BITS;
  localparam int ST_P2   = ST_DIV + 2;
  localparam int LAT     = ST_P2 + 1;
  localparam int CR_LEN  = ST_P2 - 2;
  localparam int S_IDX   = ST_SQRT + 1 - 3;

  typedef logic signed [15:0]       fx_t;
  typedef logic signed [16:0]       fxn_t;
  typedef logic signed [33:0]       ang_t;
  typedef logic [ANG_BITS:0]        root_t;
  typedef logic signed [QUO_BITS:0] wt_t;

  typedef enum logic [1:0] {
    PATH_SLERP = 2'd0,
    PATH_LOW   = 2'd1,
    PATH_HIGH  = 2'd2,
    PATH_DEGEN = 2'd3
  } path_t;

  typedef struct packed {
    fx_t  [3:0] q;
    fxn_t [3:0] r;
    fx_t        t;
    path_t      path;
    root_t      s;
  } carry_t;

  localparam ang_t INV_GAIN = 34'sd652032874;

  localparam ang_t ATAN_LUT [CORDIC_STEPS] = '{
    34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158, 34'sd67021686,
    34'sd33543515, 34'sd16775850, 34'sd8388437, 34'sd4194282, 34'sd2097149,
    34'sd1048575, 34'sd524287, 34'sd262143, 34'sd131071, 34'sd65535,
    34'sd32767, 34'sd16383, 34'sd8191, 34'sd4095, 34'sd2047,
    34'sd1023, 34'sd511, 34'sd255, 34'sd127, 34'sd63,
    34'sd31, 34'sd15, 34'sd7, 34'sd3, 34'sd1
  };

endpackage

>>> rtl/quaternion_slerp_top.sv
// ----------------------------------------------------------------------------
// quaternion_slerp_top
// Fixed-point quaternion slerp, fully pipelined.
// Throughput: one item per cycle; a stalled output freezes every stage at once.
// Depth: square root 31 stages, two CORDIC chains 30 each, weight dividers 46.
// Reset clears the valid pipeline only; data registers are not reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_slerp_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] q_x,
  input  logic signed [15:0] q_y,
  input  logic signed [15:0] q_z,
  input  logic signed [15:0] q_w,
  input  logic signed [15:0] r_x,
  input  logic signed [15:0] r_y,
  input  logic signed [15:0] r_z,
  input  logic signed [15:0] r_w,
  input  logic signed [15:0] blend,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic signed [15:0] out_w,
  output logic [1:0]         path
);
  import qslerp_pkg::*;

  localparam fx_t             ONE     = fx_t'(1 << FRAC_BITS);
  localparam fxn_t            ONE_N   = fxn_t'(1 << FRAC_BITS);
  localparam logic [33:0]     DEG_LIM = 34'd1 << (2 * FRAC_BITS);
  localparam logic [SQ_W-1:0] RAD_TOP = SQ_W'(1) << (2 * ANG_BITS);
  localparam logic signed [65:0] ROUND = 66'sd1 <<< (ANG_BITS - 1);

  logic           en;
  logic [LAT-1:0] vld;

  fx_t qin [4];
  fx_t rin [4];

  // front end
  logic signed [31:0] prod1 [4];
  fx_t                q1 [4], r1 [4], q2 [4], r2 [4];
  fx_t                t1, t2;
  logic signed [33:0] d2;
  logic [33:0]        ud;
  path_t              path3;
  carry_t             cr3;
  logic [29:0]        c3, c4;
  logic [59:0]        c2;
  logic [SQ_W-1:0]    rad;

  carry_t crl [CR_LEN];
  carry_t cr_s;

  // square root
  logic [SQ_W-1:0] sqv [SQRT_STEPS-1];
  logic [SQ_W-1:0] sqr [SQRT_STEPS-1];
  logic [29:0]     sqc [SQRT_STEPS];
  root_t           sq_s;

  // atan2
  ang_t ax [CORDIC_STEPS-1];
  ang_t ay [CORDIC_STEPS-1];
  ang_t az [CORDIC_STEPS-1];
  ang_t th;

  // angle split
  fxn_t               tt;
  logic signed [50:0] pa, pb;
  ang_t               ang_a, ang_b;
  ang_t               sin_a, sin_b;
  wt_t                w1, w2;

  // weighting
  logic signed [40:0] pql [4];
  logic signed [37:0] pqh [4];
  logic signed [41:0] prl [4];
  logic signed [38:0] prh [4];
  logic signed [65:0] acc [4];
  logic signed [35:0] scaled [4];
  fx_t                res [4];
  carry_t             cro;

  logic root_chk;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  assign qin[0] = q_x;
  assign qin[1] = q_y;
  assign qin[2] = q_z;
  assign qin[3] = q_w;
  assign rin[0] = r_x;
  assign rin[1] = r_y;
  assign rin[2] = r_z;
  assign rin[3] = r_w;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        prod1[k] <= qin[k] * rin[k];
        q1[k]    <= qin[k];
        r1[k]    <= rin[k];
        q2[k]    <= q1[k];
        r2[k]    <= r1[k];
      end
      t1 <= blend;
      t2 <= t1;
      d2 <= 34'(prod1[0]) + 34'(prod1[1]) + 34'(prod1[2]) + 34'(prod1[3]);
    end
  end

  assign ud = d2[33] ? 34'(-d2) : 34'(d2);

  always_comb begin
    if (t2 <= 0) begin
      path3 = PATH_LOW;
    end else if (t2 >= ONE) begin
      path3 = PATH_HIGH;
    end else if (ud >= DEG_LIM) begin
      path3 = PATH_DEGEN;
    end else begin
      path3 = PATH_SLERP;
    end
    for (int k = 0; k < 4; k++) begin
      cr3.q[k] = q2[k];
      if (path3 == PATH_SLERP && d2[33]) begin
        cr3.r[k] = -fxn_t'(r2[k]);
      end else begin
        cr3.r[k] = fxn_t'(r2[k]);
      end
    end
    cr3.t    = t2;
    cr3.path = path3;
    cr3.s    = '0;
  end

  // square root result joins the carry as it leaves the root stage
  always_comb begin
    cr_s   = crl[S_IDX-1];
    cr_s.s = sq_s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3 <= 30'(ud << (ANG_BITS - 2 * FRAC_BITS));
      c2 <= c3 * c3;
      c4 <= c3;
      crl[0] <= cr3;
      for (int i = 1; i < CR_LEN; i++) begin
        crl[i] <= (i == S_IDX) ? cr_s : crl[i-1];
      end
    end
  end

  assign rad = RAD_TOP - SQ_W'(c2);

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [SQ_W-1:0] vi, ri, trial, vn, rn;
    logic [29:0]     ci;
    if (k == 0) begin : g_first
      assign vi = rad;
      assign ri = '0;
      assign ci = c4;
    end else begin : g_next
      assign vi = sqv[k-1];
      assign ri = sqr[k-1];
      assign ci = sqc[k-1];
    end
    assign trial = ri + BIT;
    assign vn    = (vi >= trial) ? vi - trial : vi;
    assign rn    = (vi >= trial) ? (ri >> 1) + BIT : ri >> 1;
    always_ff @(posedge clk) begin
      if (en) begin
        sqc[k] <= ci;
      end
    end
    if (k < SQRT_STEPS - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (en) begin
          sqv[k] <= vn;
          sqr[k] <= rn;
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (en) begin
          sq_s <= rn[ANG_BITS:0];
        end
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_atan
    ang_t xi, yi, zi;
    if (i == 0) begin : g_first
      assign xi = ang_t'({4'b0, sqc[SQRT_STEPS-1]});
      assign yi = ang_t'({3'b0, sq_s});
      assign zi = '0;
    end else begin : g_next
      assign xi = ax[i-1];
      assign yi = ay[i-1];
      assign zi = az[i-1];
    end
    if (i < CORDIC_STEPS - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (en) begin
          if (yi > 0) begin
            ax[i] <= xi + (yi >>> i);
            ay[i] <= yi - (xi >>> i);
            az[i] <= zi + ATAN_LUT[i];
          end else begin
            ax[i] <= xi - (yi >>> i);
            ay[i] <= yi + (xi >>> i);
            az[i] <= zi - ATAN_LUT[i];
          end
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (en) begin
          th <= (yi > 0) ? zi + ATAN_LUT[i] : zi - ATAN_LUT[i];
        end
      end
    end
  end

  assign tt = fxn_t'(crl[ST_ATAN-3].t);
  assign pb = th * tt;
  assign pa = th * (ONE_N - tt);

  always_ff @(posedge clk) begin
    if (en) begin
      ang_a <= pa[FRAC_BITS +: $bits(ang_t)];
      ang_b <= pb[FRAC_BITS +: $bits(ang_t)];
    end
  end

  qslerp_sin u_sin_a (.clk(clk), .en(en), .angle(ang_a), .sine(sin_a));
  qslerp_sin u_sin_b (.clk(clk), .en(en), .angle(ang_b), .sine(sin_b));

  qslerp_div u_div_a (
    .clk(clk), .en(en), .sine(sin_a), .sinth(crl[ST_SIN-3].s), .weight(w1)
  );
  qslerp_div u_div_b (
    .clk(clk), .en(en), .sine(sin_b), .sinth(crl[ST_SIN-3].s), .weight(w2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        pql[k] <= crl[ST_DIV-3].q[k] * $signed({1'b0, w1[SPLIT-1:0]});
        pqh[k] <= crl[ST_DIV-3].q[k] * $signed(w1[QUO_BITS:SPLIT]);
        prl[k] <= crl[ST_DIV-3].r[k] * $signed({1'b0, w2[SPLIT-1:0]});
        prh[k] <= crl[ST_DIV-3].r[k] * $signed(w2[QUO_BITS:SPLIT]);
        acc[k] <= (66'(pqh[k]) <<< SPLIT) + 66'(pql[k])
                + (66'(prh[k]) <<< SPLIT) + 66'(prl[k]) + ROUND;
      end
    end
  end

  assign cro = crl[ST_P2-3];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      scaled[k] = 36'(acc[k] >>> ANG_BITS);
      unique case (cro.path) inside
        PATH_LOW, PATH_DEGEN: res[k] = cro.q[k];
        PATH_HIGH:            res[k] = cro.r[k][15:0];
        default: begin
          if (scaled[k] > 36'sd32767) begin
            res[k] = 16'sh7fff;
          end else if (scaled[k] < -36'sd32768) begin
            res[k] = 16'sh8000;
          end else begin
            res[k] = scaled[k][15:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x <= res[0];
      out_y <= res[1];
      out_z <= res[2];
      out_w <= res[3];
      path  <= cro.path;
    end
  end

  assign root_chk = vld[ST_SQRT-1] && crl[ST_SQRT-3].path == PATH_SLERP;

  `ASSERT_NEXT(a_stall_hold, !en, vld == $past(vld), "pipeline moved during stall")
  `ASSERT_IMPLY(a_root_pos, root_chk, sq_s != '0, "zero sine of angle on slerp path")
  `ASSERT_IMPLY(a_reset_empty, $past(rst), !out_valid, "output valid right after reset")

endmodule

>>> rtl/qslerp_sin.sv
// ----------------------------------------------------------------------------
// qslerp_sin
// Pipelined CORDIC rotation, one iteration per stage, returns sin of a Q30 angle.
// ----------------------------------------------------------------------------
module qslerp_sin (
  input  logic              clk,
  input  logic              en,
  input  qslerp_pkg::ang_t  angle,
  output qslerp_pkg::ang_t  sine
);
  import qslerp_pkg::*;

  ang_t xs [CORDIC_STEPS-1];
  ang_t ys [CORDIC_STEPS-1];
  ang_t zs [CORDIC_STEPS-1];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    ang_t xi, yi, zi;
    if (i == 0) begin : g_first
      assign xi = INV_GAIN;
      assign yi = '0;
      assign zi = angle;
    end else begin : g_next
      assign xi = xs[i-1];
      assign yi = ys[i-1];
      assign zi = zs[i-1];
    end
    if (i < CORDIC_STEPS - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (en) begin
          if (!zi[$bits(ang_t)-1]) begin
            xs[i] <= xi - (yi >>> i);
            ys[i] <= yi + (xi >>> i);
            zs[i] <= zi - ATAN_LUT[i];
          end else begin
            xs[i] <= xi + (yi >>> i);
            ys[i] <= yi - (xi >>> i);
            zs[i] <= zi + ATAN_LUT[i];
          end
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (en) begin
          if (!zi[$bits(ang_t)-1]) begin
            sine <= yi + (xi >>> i);
          end else begin
            sine <= yi - (xi >>> i);
          end
        end
      end
    end
  end

endmodule

>>> rtl/qslerp_div.sv
// ----------------------------------------------------------------------------
// qslerp_div
// Pipelined restoring divider, one quotient bit per stage: sine * 2^30 / root,
// truncated toward zero.
// ----------------------------------------------------------------------------
module qslerp_div (
  input  logic              clk,
  input  logic              en,
  input  qslerp_pkg::ang_t  sine,
  input  qslerp_pkg::root_t sinth,
  output qslerp_pkg::wt_t   weight
);
  import qslerp_pkg::*;

  localparam int DVD_W = REM_W + ANG_BITS;

  logic             neg_in;
  logic [REM_W-1:0] mag;
  logic [DVD_W-1:0] dividend;

  logic [REM_W-1:0]    rem0;
  logic [QUO_BITS-1:0] dvd0;
  root_t               dsr0;
  logic                neg0;

  logic [REM_W-1:0]    rems [QUO_BITS-1];
  logic [QUO_BITS-1:0] quos [QUO_BITS-1];
  logic [QUO_BITS-1:0] dvds [QUO_BITS-1];
  root_t               dsrs [QUO_BITS-1];
  logic                negs [QUO_BITS-1];

  assign neg_in   = sine[$bits(ang_t)-1];
  assign mag      = neg_in ? REM_W'(-sine) : REM_W'(sine);
  assign dividend = {mag, ANG_BITS'(0)};

  always_ff @(posedge clk) begin
    if (en) begin
      rem0 <= REM_W'(dividend[DVD_W-1:QUO_BITS]);
      dvd0 <= dividend[QUO_BITS-1:0];
      dsr0 <= sinth;
      neg0 <= neg_in;
    end
  end

  for (genvar j = 0; j < QUO_BITS; j++) begin : g_stage
    logic [REM_W-1:0]    ri, r2, rn;
    logic [QUO_BITS-1:0] qi, qn;
    logic [QUO_BITS-1:0] di;
    root_t               si;
    logic                ni, ge;
    if (j == 0) begin : g_first
      assign ri = rem0;
      assign qi = '0;
      assign di = dvd0;
      assign si = dsr0;
      assign ni = neg0;
    end else begin : g_next
      assign ri = rems[j-1];
      assign qi = quos[j-1];
      assign di = dvds[j-1];
      assign si = dsrs[j-1];
      assign ni = negs[j-1];
    end
    assign r2 = {ri[REM_W-2:0], di[QUO_BITS-1-j]};
    assign ge = (r2 >= REM_W'(si));
    assign rn = ge ? r2 - REM_W'(si) : r2;
    assign qn = {qi[QUO_BITS-2:0], ge};
    if (j < QUO_BITS - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (en) begin
          rems[j] <= rn;
          quos[j] <= qn;
          dvds[j] <= di;
          dsrs[j] <= si;
          negs[j] <= ni;
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (en) begin
          weight <= ni ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
        end
      end
    end
  end

endmodule
